[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);
`endif

[hw/rtl/ntls_pkg.sv]
// Package: types, codes and widths of the node table selector
package ntls_pkg;
    localparam int TableDepthDef = 16;
    localparam int InWidth  = 184;
    localparam int OutWidth = 192;

    typedef enum logic [2:0] {
        CMD_INIT = 3'd0, CMD_ADD = 3'd1, CMD_REMOVE = 3'd2, CMD_FIND = 3'd3,
        CMD_STATUS = 3'd4, CMD_HEARTBEAT = 3'd5, CMD_SELECT = 3'd6, CMD_LOAD = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ERR_OK = 3'd0, ERR_INVALID = 3'd1, ERR_FULL = 3'd2, ERR_EXISTS = 3'd3,
        ERR_NOTFOUND = 3'd4
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_CHECK, ST_SHIFT, ST_UPDATE, ST_OUT
    } state_t;

    typedef struct packed {
        logic [63:0] id;
        logic [1:0]  status;
        logic [31:0] load;
        logic [15:0] port;
        logic [63:0] stamp;
    } entry_t;
endpackage

[hw/rtl/node_table_least_load_select_core.sv]
// Top level: node membership table with least-load selection
//
// channel | dir | tdata                                                     | tuser
// s_      | in  | cmd,node_id,port,status_value,load_value,now (181 in 184) | -
// m_      | out | err,found,selected_id,entry_status,entry_load,entry_port,
//         |     | entry_heartbeat,entry_count (187 bits in 192)             | -
//
// One item at a time. Each command but init walks the table through the single read
// port of the entry memory, reading and then checking one entry at a time; a select
// walks every live entry, any other command stops its walk at a hit, and a remove
// then shifts one entry a cycle to close the gap.
// Reset empties the table at once (count cleared); the memory needs no clearing.
// A result waits in its output register; the next item is taken once it is gone.
`include "assert_macros.svh"
module node_table_least_load_select_core #(
    parameter int TABLE_DEPTH = ntls_pkg::TableDepthDef
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // cmd[2:0] node_id[66:3] port[82:67] status_value[84:83] load_value[116:85]
    // now[180:117], zero fill above
    input  logic [ntls_pkg::InWidth-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // err[2:0] found[3] selected_id[67:4] entry_status[69:68] entry_load[101:70]
    // entry_port[117:102] entry_heartbeat[181:118] entry_count[186:182]
    output logic [ntls_pkg::OutWidth-1:0] m_tdata
);
    import ntls_pkg::*;

    localparam int IdxW = $clog2(TABLE_DEPTH);
    localparam int CntW = $clog2(TABLE_DEPTH + 1);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data;
    logic           wr_en;
    logic [IdxW-1:0] wr_addr, rd_addr;
    entry_t         wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    state_t state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next, ptr_reg, ptr_next, idx_reg, idx_next;
    logic [63:0] self_reg, self_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [63:0] id_reg, id_next, now_reg, now_next;
    logic [15:0] port_reg, port_next;
    logic [1:0]  sv_reg, sv_next;
    logic [31:0] lv_reg, lv_next;
    logic        hit_reg, hit_next;
    logic        best_ok_reg, best_ok_next;
    logic [31:0] best_reg, best_next;
    logic [63:0] sel_reg, sel_next;
    entry_t      ent_reg, ent_next;
    logic        ovalid_reg, ovalid_next;
    logic [OutWidth-1:0] odata_reg, odata_next;
    logic [2:0]  err;
    logic        fnd;
    logic [63:0] osel;
    entry_t      oent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            self_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            self_reg   <= self_next;
            ovalid_reg <= ovalid_next;
        end
        ptr_reg <= ptr_next;  idx_reg <= idx_next;  cmd_reg <= cmd_next;
        id_reg <= id_next;    now_reg <= now_next;  port_reg <= port_next;
        sv_reg <= sv_next;    lv_reg <= lv_next;    hit_reg <= hit_next;
        best_ok_reg <= best_ok_next; best_reg <= best_next; sel_reg <= sel_next;
        ent_reg <= ent_next;  odata_reg <= odata_next;
    end

    assign s_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    always_comb begin
        state_next = state_reg;   count_next = count_reg; self_next = self_reg;
        ptr_next = ptr_reg;       idx_next = idx_reg;     cmd_next = cmd_reg;
        id_next = id_reg;         now_next = now_reg;     port_next = port_reg;
        sv_next = sv_reg;         lv_next = lv_reg;       hit_next = hit_reg;
        best_ok_next = best_ok_reg; best_next = best_reg; sel_next = sel_reg;
        ent_next = ent_reg;       odata_next = odata_reg;
        ovalid_next = ovalid_reg && !m_tready;
        wr_en = 1'b0;  wr_addr = idx_reg[IdxW-1:0];  wr_data = ent_reg;
        rd_addr = ptr_reg[IdxW-1:0];
        err = ERR_OK;  fnd = 1'b0;  osel = '0;  oent = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd_next  = s_tdata[2:0];
                    id_next   = s_tdata[66:3];
                    port_next = s_tdata[82:67];
                    sv_next   = s_tdata[84:83];
                    lv_next   = s_tdata[116:85];
                    now_next  = s_tdata[180:117];
                    ptr_next  = '0;
                    hit_next  = 1'b0;
                    best_ok_next = 1'b0;
                    sel_next  = self_reg;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // issue read of entry ptr; data arrives next cycle
                if (cmd_reg == CMD_INIT || ptr_reg >= count_reg) begin
                    state_next = ST_UPDATE;
                end else begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                ptr_next = ptr_reg + 1'b1;
                state_next = ST_READ;
                if (cmd_reg == CMD_SELECT) begin
                    if (rd_data.status == 2'd0 && (!best_ok_reg || rd_data.load < best_reg))
                    begin
                        best_ok_next = 1'b1;
                        best_next = rd_data.load;
                        sel_next = rd_data.id;
                    end
                end else if (rd_data.id == id_reg) begin
                    hit_next = 1'b1;
                    idx_next = ptr_reg;
                    ent_next = rd_data;
                    state_next = ST_UPDATE;
                end
            end
            ST_SHIFT: begin
                // rd_data holds entry idx+1; write it to idx
                wr_en = 1'b1;
                wr_addr = idx_reg[IdxW-1:0];
                wr_data = rd_data;
                idx_next = idx_reg + 1'b1;
                rd_addr = ptr_reg[IdxW-1:0] + 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg + 1'b1 >= count_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_UPDATE: begin
                state_next = ST_OUT;
                case (cmd_reg)
                    CMD_INIT: begin
                        self_next = id_reg;
                        wr_en = 1'b1;  wr_addr = '0;
                        wr_data = '{id: id_reg, status: 2'd0, load: '0,
                                    port: port_reg, stamp: now_reg};
                        count_next = CntW'(1);
                    end
                    CMD_ADD: begin
                        if (count_reg >= CntW'(TABLE_DEPTH)) err = ERR_FULL;
                        else if (hit_reg) err = ERR_EXISTS;
                        else begin
                            wr_en = 1'b1;  wr_addr = count_reg[IdxW-1:0];
                            wr_data = '{id: id_reg, status: 2'd0, load: '0,
                                        port: port_reg, stamp: now_reg};
                            count_next = count_reg + 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (id_reg == self_reg) err = ERR_INVALID;
                        else if (!hit_reg) err = ERR_NOTFOUND;
                        else if (idx_reg + 1'b1 >= count_reg) begin
                            count_next = count_reg - 1'b1;
                        end else begin
                            // prefetch entry idx+1, then compact
                            rd_addr = idx_reg[IdxW-1:0] + 1'b1;
                            ptr_next = idx_reg + 1'b1;
                            state_next = ST_SHIFT;
                        end
                    end
                    CMD_SELECT: ;
                    default: begin
                        if (!hit_reg) err = ERR_NOTFOUND;
                        else begin
                            fnd = 1'b1;
                            oent = ent_reg;
                            if (cmd_reg == CMD_STATUS) oent.status = sv_reg;
                            else if (cmd_reg == CMD_HEARTBEAT) oent.stamp = now_reg;
                            else if (cmd_reg == CMD_LOAD) oent.load = lv_reg;
                            wr_en = (cmd_reg != CMD_FIND);
                            wr_data = oent;
                        end
                    end
                endcase
                if (cmd_reg == CMD_SELECT && count_reg != '0) osel = sel_reg;
                odata_next = '0;
                odata_next[2:0]     = err;
                odata_next[3]       = fnd;
                odata_next[67:4]    = osel;
                odata_next[69:68]   = oent.status;
                odata_next[101:70]  = oent.load;
                odata_next[117:102] = oent.port;
                odata_next[181:118] = oent.stamp;
                odata_next[186:182] = 5'(count_next);
                if (state_next == ST_OUT) begin
                    ovalid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                odata_next = '0;
                odata_next[186:182] = 5'(count_reg);
                ovalid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `ASSERT_CLK(a_count_range, count_reg <= CntW'(TABLE_DEPTH), "count exceeds depth")
    `ASSERT_CLK(a_ready_idle, !(s_tready && ovalid_reg), "ready with result pending")
    `ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_reg == ST_READ,
        "accepted item did not start a walk")
    `ASSERT_NEXT(a_shift_cnt, state_reg == ST_SHIFT && state_next == ST_OUT,
        count_reg == $past(count_reg) - 1'b1, "remove did not shrink table")
endmodule
